// ===== hdl/kne_pkg.sv =====
package kne_pkg;

	// Default width of the stored entry value and fixed width of the reported number.
	localparam int unsigned VALUE_WIDTH_DEF = 30;
	localparam int unsigned NUM_W           = 30;

	localparam int unsigned COL_W    = 4;
	localparam int unsigned ROW_W    = 4;
	localparam int unsigned CODE_W   = 7;
	localparam int unsigned DIGITS_W = 4;

	localparam logic [DIGITS_W-1:0] MAX_DIGITS_RST = 4'd9;

	// Key codes with a meaning of their own.
	localparam logic [CODE_W-1:0] KEY_BLANK   = 7'h20;
	localparam logic [CODE_W-1:0] KEY_DIGIT_0 = 7'h30;
	localparam logic [CODE_W-1:0] KEY_DIGIT_9 = 7'h39;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_SCAN    = 2'd1,
		PH_RELEASE = 2'd2
	} phase_t;

	// Lowest column pulled low; column 3 when none of columns 0 to 2 is low.
	function automatic logic [1:0] lowest_low_col(input logic [COL_W-1:0] cols);
		logic [1:0] c;
		if (!cols[0]) begin
			c = 2'd0;
		end else if (!cols[1]) begin
			c = 2'd1;
		end else if (!cols[2]) begin
			c = 2'd2;
		end else begin
			c = 2'd3;
		end
		return c;
	endfunction

	// Fixed 4x4 key layout, ASCII codes.
	function automatic logic [CODE_W-1:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
		logic [CODE_W-1:0] k;
		unique case ({row, col})
			4'h0: k = 7'h31; // 1
			4'h1: k = 7'h32; // 2
			4'h2: k = 7'h33; // 3
			4'h3: k = KEY_BLANK;
			4'h4: k = 7'h34; // 4
			4'h5: k = 7'h35; // 5
			4'h6: k = 7'h36; // 6
			4'h7: k = 7'h2D; // -
			4'h8: k = 7'h37; // 7
			4'h9: k = 7'h38; // 8
			4'hA: k = 7'h39; // 9
			4'hB: k = 7'h2F; // /
			4'hC: k = 7'h26; // &
			4'hD: k = 7'h30; // 0
			4'hE: k = 7'h5E; // ^
			4'hF: k = 7'h2A; // *
			default: k = 7'h00;
		endcase
		return k;
	endfunction

endpackage

// ===== hdl/keypad_number_entry.sv =====
// Keypad number entry: scans a 4x4 active-low key matrix and builds a decimal number.
// Input stream: one request per scan tick, tdata carrying the sampled column pins.
// Output stream: one result per request, giving the row pattern under which those
// columns were sampled, any decoded key and the entry state after the tick.
// Configuration: a write channel carrying max_digits, taken in any cycle and meant
// to be written only while the block is idle.
// A request's result is loaded into the output register at the edge that accepts it.
// Throughput is one request per cycle unless the receiver stalls; deleting the last
// digit divides the entry by ten with a reciprocal multiplication in the same cycle.
// The result sits in an output register; while the receiver stalls it is held and
// s_axis_tready stays low, and the block still takes a new request in the cycle that
// the held result is taken.
// Reset returns the scanner to waiting for a press, clears the entry and the digit
// count, sets max_digits to 9 and empties the output register.
// Keys: digits append to the entry while under max_digits, the blank key deletes the
// last digit; all other keys report the number with number_valid and clear the entry.
module keypad_number_entry #(
	parameter int unsigned VALUE_WIDTH = kne_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side, tdata: column_lines[3:0], zeros [7:4].
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	// Master side, tdata: row_drive[3:0], key_code[10:4], number_value[40:11],
	// digit_count[44:41], zeros [47:45].
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,
	// Master side, tuser: key_valid[0], number_valid[1].
	output logic [1:0]  m_axis_tuser,
	// Configuration write: max_digits.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [kne_pkg::DIGITS_W-1:0] cfg_data
);
	import kne_pkg::*;

	// Reciprocal of ten scaled by 2^(VALUE_WIDTH+3) and rounded up; exact for every
	// entry value that fits in VALUE_WIDTH bits.
	localparam logic [VALUE_WIDTH+3:0] DIV10_ONE = {1'b1, {(VALUE_WIDTH + 3){1'b0}}};
	localparam logic [VALUE_WIDTH-1:0] DIV10_MUL =
		VALUE_WIDTH'(DIV10_ONE / (VALUE_WIDTH + 4)'(10) + (VALUE_WIDTH + 4)'(1));

	// Scanner and entry state.
	phase_t                  phase_q, phase_d;
	logic [1:0]              row_q, row_d;
	logic [VALUE_WIDTH-1:0]  entry_q, entry_d;
	logic [DIGITS_W-1:0]     digits_q, digits_d;
	logic [DIGITS_W-1:0]     max_digits_q;

	// Output register.
	logic                    m_valid_q;
	logic [ROW_W-1:0]        row_drive_q;
	logic                    key_valid_q;
	logic [CODE_W-1:0]       key_code_q;
	logic                    number_valid_q;
	logic [NUM_W-1:0]        number_value_q;
	logic [DIGITS_W-1:0]     digit_count_q;

	// Combinational results of the current request.
	logic [COL_W-1:0]        cols;
	logic                    pressed;
	logic [ROW_W-1:0]        row_drive;
	logic                    key_valid;
	logic [CODE_W-1:0]       key_code;
	logic                    number_valid;
	logic [VALUE_WIDTH-1:0]  number_value;
	logic [VALUE_WIDTH-1:0]  append_val;
	logic [2*VALUE_WIDTH-1:0] div_prod;
	logic [VALUE_WIDTH-1:0]  entry_div10;
	logic [3:0]              digit_val;
	logic                    s_fire;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	assign cols      = s_axis_tdata[COL_W-1:0];
	assign pressed   = (cols != {COL_W{1'b1}});
	assign digit_val = key_code[3:0];
	// entry * 10 + digit, kept modulo 2^VALUE_WIDTH
	assign append_val = (entry_q << 3) + (entry_q << 1) + VALUE_WIDTH'(digit_val);
	// entry / 10 for the deletion of the last digit
	assign div_prod    = (2 * VALUE_WIDTH)'(entry_q) * (2 * VALUE_WIDTH)'(DIV10_MUL);
	assign entry_div10 = VALUE_WIDTH'(div_prod >> (VALUE_WIDTH + 3));

	// Scanner: next phase and the key decoded in this tick.
	always_comb begin
		phase_d   = phase_q;
		row_d     = row_q;
		row_drive = '0;
		key_valid = 1'b0;
		key_code  = '0;
		unique case (phase_q)
			PH_SCAN: begin
				row_drive = ~(ROW_W'(1) << row_q);
				if (pressed) begin
					key_code  = key_lookup(row_q, lowest_low_col(cols));
					key_valid = 1'b1;
					phase_d   = PH_RELEASE;
				end else if (row_q == 2'd3) begin
					// No row showed the key: give up and wait for a fresh press.
					phase_d = PH_IDLE;
					row_d   = 2'd0;
				end else begin
					row_d = row_q + 2'd1;
				end
			end
			PH_RELEASE: begin
				if (!pressed) begin
					phase_d = PH_IDLE;
				end
			end
			PH_IDLE: begin
				if (pressed) begin
					phase_d = PH_SCAN;
					row_d   = 2'd0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Entry update for the decoded key.
	always_comb begin
		entry_d      = entry_q;
		digits_d     = digits_q;
		number_valid = 1'b0;
		if (key_valid) begin
			if (key_code == KEY_BLANK) begin
				if (digits_q != '0) begin
					digits_d = digits_q - DIGITS_W'(1);
					entry_d  = entry_div10;
				end
			end else if (key_code >= KEY_DIGIT_0 && key_code <= KEY_DIGIT_9) begin
				if (digits_q < max_digits_q) begin
					entry_d  = append_val;
					digits_d = digits_q + DIGITS_W'(1);
				end
			end else begin
				number_valid = 1'b1;
				entry_d      = '0;
				digits_d     = '0;
			end
		end
		number_value = number_valid ? entry_q : entry_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			row_q    <= 2'd0;
			entry_q  <= '0;
			digits_q <= '0;
		end else if (s_fire) begin
			phase_q  <= phase_d;
			row_q    <= row_d;
			entry_q  <= entry_d;
			digits_q <= digits_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_digits_q <= MAX_DIGITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_digits_q <= cfg_data;
		end
	end

	// Output register: loads on every accepted request, empties when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			row_drive_q    <= row_drive;
			key_valid_q    <= key_valid;
			key_code_q     <= key_code;
			number_valid_q <= number_valid;
			number_value_q <= NUM_W'(number_value);
			digit_count_q  <= digits_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, digit_count_q, number_value_q, key_code_q, row_drive_q};
	assign m_axis_tuser  = {number_valid_q, key_valid_q};

endmodule

// ===== verif/tb_keypad_number_entry.sv =====
`timescale 1ns / 100ps

module tb_keypad_number_entry;
	import kne_pkg::*;

	// One result of a scan tick, field by field.
	typedef struct packed {
		logic [ROW_W-1:0]    rows;
		logic                key_hit;
		logic [CODE_W-1:0]   code;
		logic                number_done;
		logic [NUM_W-1:0]    value;
		logic [DIGITS_W-1:0] count;
	} scan_result_t;

	// One row of the directed table. Where typed is set, want is the result to be seen;
	// otherwise the result comes from the scanner model.
	typedef struct packed {
		logic [COL_W-1:0] cols;
		logic             typed;
		scan_result_t     want;
	} stim_row_t;

	localparam int unsigned DIRECTED_ROWS = 25;
	localparam int unsigned PHASE_COUNT   = 6;
	localparam int unsigned PHASE_ITEMS   = 115;
	// Generous bound: every request may wait out a long sender gap and a receiver
	// that takes one result in four.
	localparam int unsigned CYCLE_LIMIT   = 300000;
	// Idle cycles after the last result before the register is touched.
	localparam int unsigned SETTLE_CYCLES = 16;

	localparam logic [COL_W-1:0]  COLS_NONE = 4'hF;
	localparam logic [CODE_W-1:0] CODE_ONE  = 7'h31;
	localparam logic [CODE_W-1:0] CODE_AMP  = 7'h26;
	localparam int                POS_BLANK = 3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [47:0]         m_axis_tdata;
	logic [1:0]          m_axis_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [DIGITS_W-1:0] cfg_data = '0;

	keypad_number_entry dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// Scanner model state, a copy of what the block should hold after each request.
	phase_t              scan_ph = PH_IDLE;
	logic [1:0]          scan_row = '0;
	logic [NUM_W-1:0]    entry_val = '0;
	logic [DIGITS_W-1:0] entry_cnt = '0;
	logic [DIGITS_W-1:0] digit_limit = MAX_DIGITS_RST;

	scan_result_t pending_results[$];
	stim_row_t    dir_table [DIRECTED_ROWS];
	int unsigned  mismatches = 0;
	int unsigned  requests_sent = 0;
	int unsigned  cycle_count = 0;
	int           burst_left = 0;

	// ASCII code printed on the key at a given matrix position, row * 4 + column.
	function automatic logic [CODE_W-1:0] keypad_code(input int pos);
		logic [CODE_W-1:0] k;
		case (pos)
			0:  k = 7'h31;  // 1
			1:  k = 7'h32;  // 2
			2:  k = 7'h33;  // 3
			3:  k = 7'h20;  // blank
			4:  k = 7'h34;  // 4
			5:  k = 7'h35;  // 5
			6:  k = 7'h36;  // 6
			7:  k = 7'h2D;  // -
			8:  k = 7'h37;  // 7
			9:  k = 7'h38;  // 8
			10: k = 7'h39;  // 9
			11: k = 7'h2F;  // /
			12: k = 7'h26;  // &
			13: k = 7'h30;  // 0
			14: k = 7'h5E;  // ^
			default: k = 7'h2A;  // *
		endcase
		return k;
	endfunction

	// Advances the scanner model by one tick on the sampled columns and gives the result
	// that the block should report for it.
	task automatic scan_tick(input logic [COL_W-1:0] cols, output scan_result_t r);
		logic        pressed;
		logic [1:0]  col;
		logic [33:0] wide;
		int          c;
		r = '0;
		pressed = (cols != COLS_NONE);
		case (scan_ph)
			PH_SCAN: begin
				r.rows = ~(4'b0001 << scan_row);
				if (pressed) begin
					// The lowest column pulled low wins; column 3 when 0 to 2 are high.
					col = 2'd3;
					for (c = 2; c >= 0; c--) begin
						if (!cols[c]) begin
							col = c[1:0];
						end
					end
					r.key_hit = 1'b1;
					r.code = keypad_code({scan_row, col});
					scan_ph = PH_RELEASE;
				end else if (scan_row == 2'd3) begin
					// No row pulled a column low: back to waiting for a press.
					scan_ph = PH_IDLE;
					scan_row = '0;
				end else begin
					scan_row = scan_row + 2'd1;
				end
			end
			PH_RELEASE: begin
				if (!pressed) begin
					scan_ph = PH_IDLE;
				end
			end
			default: begin
				if (pressed) begin
					scan_ph = PH_SCAN;
					scan_row = '0;
				end else begin
					scan_ph = PH_IDLE;
				end
			end
		endcase

		r.value = entry_val;
		if (r.key_hit) begin
			if (r.code == KEY_BLANK) begin
				if (entry_cnt != 0) begin
					entry_cnt = entry_cnt - 1'b1;
					entry_val = entry_val / 10;
				end
				r.value = entry_val;
			end else if (r.code >= KEY_DIGIT_0 && r.code <= KEY_DIGIT_9) begin
				// Digits past the limit are decoded but leave the entry alone.
				if (entry_cnt < digit_limit) begin
					wide = entry_val * 34'd10 + (r.code - KEY_DIGIT_0);
					entry_val = wide[NUM_W-1:0];
					entry_cnt = entry_cnt + 1'b1;
				end
				r.value = entry_val;
			end else begin
				r.number_done = 1'b1;
				entry_val = '0;
				entry_cnt = '0;
			end
		end
		r.count = entry_cnt;
	endtask

	// Column levels of a physical keypad with the given keys held down, under the row
	// pattern that the block drives for its next tick.
	function automatic logic [COL_W-1:0] keypad_columns(input logic [15:0] held);
		logic [3:0]       rows_low;
		logic [COL_W-1:0] cols;
		int               r;
		int               c;
		rows_low = (scan_ph == PH_SCAN) ? (4'b0001 << scan_row) : 4'hF;
		cols = COLS_NONE;
		for (r = 0; r < 4; r++) begin
			for (c = 0; c < 4; c++) begin
				if (rows_low[r] && held[r * 4 + c]) begin
					cols[c] = 1'b0;
				end
			end
		end
		return cols;
	endfunction

	// Sends one request of column samples. The sender works in bursts; between bursts
	// it may drop tvalid for a random gap. The expected result is queued on acceptance.
	task automatic send_columns(input logic [COL_W-1:0] cols, input logic typed,
			input scan_result_t want);
		scan_result_t got;
		int           gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, cols};
		do @(posedge clk); while (!s_axis_tready);
		scan_tick(cols, got);
		pending_results.push_back(typed ? want : got);
		requests_sent++;
	endtask

	// Holds a key (and any extra keys) long enough for the scan to find it, now and then
	// letting go in the middle of the scan, and then releases with the odd bounce.
	task automatic press_key(input int pos, input logic [15:0] extra);
		logic [15:0] held;
		int          hold;
		int          rel;
		int          i;
		held = (16'h0001 << pos) | extra;
		hold = pos / 4 + 2 + $urandom_range(0, 2);
		if ($urandom_range(0, 15) == 0) begin
			hold = $urandom_range(1, pos / 4 + 1);
		end
		for (i = 0; i < hold; i++) begin
			send_columns(keypad_columns(held), 1'b0, '0);
		end
		rel = $urandom_range(1, 3);
		for (i = 0; i < rel; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				send_columns(4'($urandom_range(0, 15)), 1'b0, '0);
			end
			send_columns(keypad_columns(16'h0000), 1'b0, '0);
		end
	endtask

	// Picks a random matrix position holding a digit, or else a terminating key.
	task automatic pick_key(input logic want_digit, output int pos);
		logic [CODE_W-1:0] k;
		logic              is_digit;
		do begin
			pos = $urandom_range(0, 15);
			k = keypad_code(pos);
			is_digit = (k >= KEY_DIGIT_0 && k <= KEY_DIGIT_9);
		end while (is_digit != want_digit || k == KEY_BLANK);
	endtask

	// One number entry: a run of digits with the odd deletion, noise and chord, closed
	// by a terminating key. Runs reach past the digit limit now and then.
	task automatic enter_number();
		int          n;
		int          i;
		int          j;
		int          sel;
		int          pos;
		logic [15:0] extra;
		n = $urandom_range(0, int'(digit_limit) + 3);
		for (i = 0; i < n; i++) begin
			sel = $urandom_range(0, 11);
			extra = '0;
			if (sel == 0) begin
				press_key(POS_BLANK, extra);
			end else if (sel == 1) begin
				for (j = $urandom_range(1, 4); j > 0; j--) begin
					send_columns(4'($urandom_range(0, 15)), 1'b0, '0);
				end
			end else begin
				if (sel == 2) begin
					extra = 16'h0001 << $urandom_range(0, 15);
				end
				pick_key(1'b1, pos);
				press_key(pos, extra);
			end
		end
		pick_key(1'b0, pos);
		press_key(pos, 16'h0000);
	endtask

	// Lets the sender pause until every result has come back, then a little longer
	// before the register is touched.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_digit_limit(input logic [DIGITS_W-1:0] limit);
		cfg_valid <= 1'b1;
		cfg_data  <= limit;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		digit_limit = limit;
	endtask

	task automatic compare_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Result side: checks every accepted result against the oldest request still
	// waiting, then drives tready for the next edge. The stall pattern switches between
	// always ready, mostly ready and mostly stalled in stretches of random length.
	int stall_mode = 0;
	int mode_left = 0;
	always @(posedge clk) begin
		scan_result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_keypad_number_entry NOT OK");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request waiting, actual tdata %0h tuser %0h",
					$time, m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("row_drive", want.rows, m_axis_tdata[3:0]);
				compare_field("key_valid", want.key_hit, m_axis_tuser[0]);
				compare_field("key_code", want.code, m_axis_tdata[10:4]);
				compare_field("number_valid", want.number_done, m_axis_tuser[1]);
				compare_field("number_value", want.value, m_axis_tdata[40:11]);
				compare_field("digit_count", want.count, m_axis_tdata[44:41]);
			end
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 80);
		end
		mode_left--;
		case (stall_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	initial begin
		int i;
		int p;
		// Directed walk from reset with max_digits at 9. It presses 1 with every column
		// low at once, lets a press vanish so that the scan finds no row, enters 9 on
		// row 2, deletes it with the blank key and ends the entry with & on row 3.
		dir_table = '{
			'{4'hF, 1'b1, '{4'h0, 1'b0, 7'h00,    1'b0, 30'd0, 4'd0}},  // idle after reset
			'{4'h0, 1'b1, '{4'h0, 1'b0, 7'h00,    1'b0, 30'd0, 4'd0}},  // press seen, scan
			'{4'h0, 1'b1, '{4'hE, 1'b1, CODE_ONE, 1'b0, 30'd1, 4'd1}},  // row 0, column 0
			'{4'h0, 1'b0, '0},
			'{4'hF, 1'b0, '0},
			'{4'h7, 1'b0, '0},
			'{4'hF, 1'b0, '0},
			'{4'hF, 1'b0, '0},
			'{4'hF, 1'b0, '0},
			'{4'hF, 1'b1, '{4'h7, 1'b0, 7'h00,    1'b0, 30'd1, 4'd1}},  // no row found
			'{4'hB, 1'b0, '0},
			'{4'hF, 1'b0, '0},
			'{4'hF, 1'b0, '0},
			'{4'hB, 1'b0, '0},
			'{4'hF, 1'b0, '0},
			'{4'h7, 1'b0, '0},
			'{4'h7, 1'b0, '0},
			'{4'hF, 1'b0, '0},
			'{4'hE, 1'b0, '0},
			'{4'hF, 1'b0, '0},
			'{4'hF, 1'b0, '0},
			'{4'hF, 1'b0, '0},
			'{4'hE, 1'b1, '{4'h7, 1'b1, CODE_AMP, 1'b1, 30'd1, 4'd0}},  // entry ends
			'{4'hE, 1'b0, '0},
			'{4'hF, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++) begin
			send_columns(dir_table[i].cols, dir_table[i].typed, dir_table[i].want);
		end

		// Random phases, each under its own digit limit: a single digit, the widest
		// setting where the entry wraps, no digits at all, the reset value and two
		// random settings.
		for (p = 0; p < PHASE_COUNT; p++) begin
			drain_results();
			case (p)
				0:       write_digit_limit(4'd1);
				1:       write_digit_limit(4'd15);
				2:       write_digit_limit(4'd0);
				3:       write_digit_limit(MAX_DIGITS_RST);
				4:       write_digit_limit(4'($urandom_range(2, 8)));
				default: write_digit_limit(4'($urandom_range(0, 15)));
			endcase
			i = requests_sent;
			while (requests_sent - i < PHASE_ITEMS) begin
				enter_number();
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_keypad_number_entry OK");
		end else begin
			$display("tb_keypad_number_entry NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/kne_pkg.sv
hdl/keypad_number_entry.sv
verif/tb_keypad_number_entry.sv
